// ----- rtl/lpcp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcp_pkg: shared types and constants of the lidar point projector
// Payload structs, result status codes, register indexes and the flag group
// that travels from the front end to the output stage.
// ----------------------------------------------------------------------------
package lpcp_pkg;

	typedef struct packed {
		logic signed [31:0] pt_x;
		logic signed [31:0] pt_y;
		logic signed [31:0] pt_z;
	} pt_t;

	typedef enum logic [1:0] {
		ST_INSIDE  = 2'd0,
		ST_BAND    = 2'd1,
		ST_ZERO    = 2'd2,
		ST_OUTSIDE = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] pixel_col;
		logic [15:0] pixel_row;
	} res_t;

	// per-item flags from the projection sums and the quotient range check
	typedef struct packed {
		logic w_zero;
		logic col_neg;
		logic row_neg;
		logic col_big;
		logic row_big;
	} flag_t;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_NUM   = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW0_LO    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW0_HI    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW1_LO    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW1_HI    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW2_LO    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW2_HI    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEV_BAND  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 4'd7;

	localparam int ROOT_W = 32;  // bits of the integer square root
	localparam int QUO_W  = 16;  // bits of a pixel quotient

endpackage

// ----- rtl/lpcp_front.sv -----
// ----------------------------------------------------------------------------
// lpcp_front: products, projection sums and operand preparation
// Stage 1 multiplies, stage 2 sums, stage 3 takes magnitudes and sign flags.
// ----------------------------------------------------------------------------
module lpcp_front #(
	parameter int FRAC_BITS = 16,
	parameter int ACC_W     = 49
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  lpcp_pkg::pt_t            pt,
	input  logic [5:0][63:0]         mat,
	output logic                     valid_s3,
	output logic [63:0]              n_s3,
	output logic [ACC_W-1:0]         a_abs_s3,
	output logic [ACC_W-1:0]         b_abs_s3,
	output logic [ACC_W-1:0]         w_abs_s3,
	output logic signed [31:0]       z_s3,
	output lpcp_pkg::flag_t          flag_s3
);

	logic signed [31:0] coef [9];
	logic signed [31:0] crd  [3];
	logic [31:0]        ax, ay;

	logic               valid_s1, valid_s2;
	logic signed [63:0] prod_s1 [9];
	logic [63:0]        sqx_s1, sqy_s1;
	logic signed [31:0] z_s1, z_s2;

	logic signed [ACC_W-1:0] acc_s2 [3];
	logic [63:0]             n_s2;
	logic signed [63:0]      sum [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[3*r]   = mat[2*r][31:0];
			coef[3*r+1] = mat[2*r][63:32];
			coef[3*r+2] = mat[2*r+1][31:0];
		end
		crd[0] = pt.pt_x;
		crd[1] = pt.pt_y;
		crd[2] = pt.pt_z;
		ax = pt.pt_x[31] ? 32'(-pt.pt_x) : pt.pt_x;
		ay = pt.pt_y[31] ? 32'(-pt.pt_y) : pt.pt_y;
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = (prod_s1[3*r] >>> FRAC_BITS) + (prod_s1[3*r+1] >>> FRAC_BITS)
				+ (prod_s1[3*r+2] >>> FRAC_BITS) + 64'($signed(mat[2*r+1][63:32]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				prod_s1[i] <= coef[i] * crd[i % 3];
			end
			sqx_s1 <= 64'(ax) * 64'(ax);
			sqy_s1 <= 64'(ay) * 64'(ay);
			z_s1   <= pt.pt_z;

			for (int r = 0; r < 3; r++) begin
				acc_s2[r] <= sum[r][ACC_W-1:0];
			end
			n_s2 <= sqx_s1 + sqy_s1;
			z_s2 <= z_s1;

			a_abs_s3 <= acc_s2[0][ACC_W-1] ? ACC_W'(-acc_s2[0]) : acc_s2[0];
			b_abs_s3 <= acc_s2[1][ACC_W-1] ? ACC_W'(-acc_s2[1]) : acc_s2[1];
			w_abs_s3 <= acc_s2[2][ACC_W-1] ? ACC_W'(-acc_s2[2]) : acc_s2[2];
			n_s3     <= n_s2;
			z_s3     <= z_s2;
			// a negative quotient needs a nonzero dividend of the other sign
			flag_s3.w_zero  <= (acc_s2[2] == '0);
			flag_s3.col_neg <= (acc_s2[0] != '0) && (acc_s2[0][ACC_W-1] != acc_s2[2][ACC_W-1]);
			flag_s3.row_neg <= (acc_s2[1] != '0) && (acc_s2[1][ACC_W-1] != acc_s2[2][ACC_W-1]);
			flag_s3.col_big <= 1'b0;
			flag_s3.row_big <= 1'b0;
		end
	end

endmodule

// ----- rtl/lpcp_iter.sv -----
// ----------------------------------------------------------------------------
// lpcp_iter: bit-serial square root and pixel quotients, one bit per stage
// Each stage settles one root bit; the first stages also settle one bit of
// each quotient.
// ----------------------------------------------------------------------------
module lpcp_iter #(
	parameter int ACC_W = 49
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [63:0]          n,
	input  logic [ACC_W-1:0]     a_abs,
	input  logic [ACC_W-1:0]     b_abs,
	input  logic [ACC_W-1:0]     w_abs,
	input  logic signed [31:0]   z,
	input  lpcp_pkg::flag_t      flag,
	output logic                 out_valid,
	output logic [31:0]          root,
	output logic [15:0]          col_q,
	output logic [15:0]          row_q,
	output logic signed [31:0]   z_out,
	output lpcp_pkg::flag_t      flag_out
);

	localparam int NSTEP = lpcp_pkg::ROOT_W;
	localparam int DR_W  = ACC_W + 17;

	typedef struct packed {
		logic [63:0]        srem;
		logic [31:0]        root;
		logic [DR_W-1:0]    ra;
		logic [DR_W-1:0]    rb;
		logic [ACC_W-1:0]   wd;
		logic [15:0]        qa;
		logic [15:0]        qb;
		logic signed [31:0] z;
		lpcp_pkg::flag_t    fl;
	} it_t;

	it_t  stg_s [NSTEP+1];
	logic vld_s [NSTEP+1];

	always_comb begin
		stg_s[0].srem = n;
		stg_s[0].root = '0;
		stg_s[0].ra   = DR_W'(a_abs);
		stg_s[0].rb   = DR_W'(b_abs);
		stg_s[0].wd   = w_abs;
		stg_s[0].qa   = '0;
		stg_s[0].qb   = '0;
		stg_s[0].z    = z;
		stg_s[0].fl   = flag;
		vld_s[0]      = in_valid;
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam int SB = NSTEP - 1 - k;

		it_t             nxt;
		logic [65:0]     tr;
		logic [DR_W-1:0] ra_n, rb_n;
		logic [15:0]     qa_n, qb_n;
		lpcp_pkg::flag_t fl_n;

		if (k < lpcp_pkg::QUO_W) begin : g_div
			localparam int DB = lpcp_pkg::QUO_W - 1 - k;
			logic [DR_W-1:0] dv;
			always_comb begin
				dv   = DR_W'(stg_s[k].wd) << DB;
				ra_n = stg_s[k].ra;
				rb_n = stg_s[k].rb;
				qa_n = stg_s[k].qa;
				qb_n = stg_s[k].qb;
				fl_n = stg_s[k].fl;
				if (stg_s[k].ra >= dv) begin
					ra_n     = stg_s[k].ra - dv;
					qa_n[DB] = 1'b1;
				end
				if (stg_s[k].rb >= dv) begin
					rb_n     = stg_s[k].rb - dv;
					qb_n[DB] = 1'b1;
				end
				// quotient of 2^16 or more lies outside any image
				if (k == 0) begin
					fl_n.col_big = (stg_s[k].ra >= (DR_W'(stg_s[k].wd) << lpcp_pkg::QUO_W));
					fl_n.row_big = (stg_s[k].rb >= (DR_W'(stg_s[k].wd) << lpcp_pkg::QUO_W));
				end
			end
		end else begin : g_hold
			assign ra_n = stg_s[k].ra;
			assign rb_n = stg_s[k].rb;
			assign qa_n = stg_s[k].qa;
			assign qb_n = stg_s[k].qb;
			assign fl_n = stg_s[k].fl;
		end

		always_comb begin
			nxt    = stg_s[k];
			nxt.ra = ra_n;
			nxt.rb = rb_n;
			nxt.qa = qa_n;
			nxt.qb = qb_n;
			nxt.fl = fl_n;
			tr = (66'(stg_s[k].root) << (SB + 1)) | (66'(1) << (2 * SB));
			if (66'(stg_s[k].srem) >= tr) begin
				nxt.srem     = stg_s[k].srem - tr[63:0];
				nxt.root[SB] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[NSTEP];
	assign root      = stg_s[NSTEP].root;
	assign col_q     = stg_s[NSTEP].qa;
	assign row_q     = stg_s[NSTEP].qb;
	assign z_out     = stg_s[NSTEP].z;
	assign flag_out  = stg_s[NSTEP].fl;

endmodule

// ----- rtl/lpcp_back.sv -----
// ----------------------------------------------------------------------------
// lpcp_back: elevation gate and result stage
// Stage 1 forms the band bounds, stage 2 compares and holds the result item.
// ----------------------------------------------------------------------------
module lpcp_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [31:0]        root,
	input  logic [15:0]        col_q,
	input  logic [15:0]        row_q,
	input  logic signed [31:0] z,
	input  lpcp_pkg::flag_t    flag,
	input  logic [63:0]        band,
	input  logic [31:0]        size,
	output logic               res_valid,
	output lpcp_pkg::res_t     res
);

	logic               valid_s1;
	logic signed [64:0] lo_s1, hi_s1, zs_s1;
	logic [15:0]        col_s1, row_s1;
	lpcp_pkg::flag_t    flag_s1;
	logic signed [31:0] lo_t, hi_t;
	logic signed [32:0] dd;
	logic               pass;
	lpcp_pkg::res_t     res_d;

	assign lo_t = band[31:0];
	assign hi_t = band[63:32];
	assign dd   = {1'b0, root};

	always_comb begin
		pass            = (lo_s1 <= zs_s1) && (zs_s1 < hi_s1);
		res_d.status    = lpcp_pkg::ST_OUTSIDE;
		res_d.pixel_col = '0;
		res_d.pixel_row = '0;
		if (!pass) begin
			res_d.status = lpcp_pkg::ST_BAND;
		end else if (flag_s1.w_zero) begin
			res_d.status = lpcp_pkg::ST_ZERO;
		end else if (!(flag_s1.col_neg || flag_s1.row_neg || flag_s1.col_big
				|| flag_s1.row_big) && (col_s1 < size[15:0]) && (row_s1 < size[31:16])) begin
			res_d.status    = lpcp_pkg::ST_INSIDE;
			res_d.pixel_col = col_s1;
			res_d.pixel_row = row_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= lo_t * dd;
			hi_s1   <= hi_t * dd;
			zs_s1   <= 65'(z) <<< FRAC_BITS;
			col_s1  <= col_q;
			row_s1  <= row_q;
			flag_s1 <= flag;
			res     <= res_d;
		end
	end

endmodule

// ----- rtl/lidar_point_camera_projector.sv -----
// ----------------------------------------------------------------------------
// lidar_point_camera_projector: lidar point to camera pixel projection
// Elevation gate on the horizontal range, 3x4 projection and floor division
// to a pixel, checked against the image size.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   pt       | pt_valid / pt_stall   | pt_x, pt_y, pt_z
//   res      | res_valid / res_stall | status, pixel_col, pixel_row
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle while no result is stalled: 3 front stages,
// 32 square root stages (one root bit each, the first 16 also give one
// quotient bit), 2 gate and result stages.
// A stalled result freezes the whole pipeline; pt_stall follows at once.
// Reset clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module lidar_point_camera_projector #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pt_valid,
	output logic                             pt_stall,
	input  lpcp_pkg::pt_t                    pt,
	output logic                             res_valid,
	input  logic                             res_stall,
	output lpcp_pkg::res_t                   res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpcp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                      cfg_data
);

	localparam int ACC_W = 65 - FRAC_BITS;

	logic [63:0]        cfg_q [lpcp_pkg::CFG_NUM];
	logic [5:0][63:0]   mat;
	logic               en;

	logic               f_valid;
	logic [63:0]        f_n;
	logic [ACC_W-1:0]   f_a, f_b, f_w;
	logic signed [31:0] f_z;
	lpcp_pkg::flag_t    f_flag;

	logic               i_valid;
	logic [31:0]        i_root;
	logic [15:0]        i_col, i_row;
	logic signed [31:0] i_z;
	lpcp_pkg::flag_t    i_flag;

	assign cfg_ready = 1'b1;
	assign en        = !res_valid || !res_stall;
	assign pt_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lpcp_pkg::CFG_NUM; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lpcp_pkg::CFG_ROW0_LO:    cfg_q[0] <= cfg_data;
				lpcp_pkg::CFG_ROW0_HI:    cfg_q[1] <= cfg_data;
				lpcp_pkg::CFG_ROW1_LO:    cfg_q[2] <= cfg_data;
				lpcp_pkg::CFG_ROW1_HI:    cfg_q[3] <= cfg_data;
				lpcp_pkg::CFG_ROW2_LO:    cfg_q[4] <= cfg_data;
				lpcp_pkg::CFG_ROW2_HI:    cfg_q[5] <= cfg_data;
				lpcp_pkg::CFG_ELEV_BAND:  cfg_q[6] <= cfg_data;
				lpcp_pkg::CFG_IMAGE_SIZE: cfg_q[7] <= {32'd0, cfg_data[31:0]};
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			mat[i] = cfg_q[i];
		end
	end

	lpcp_front #(
		.FRAC_BITS (FRAC_BITS),
		.ACC_W     (ACC_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pt_valid),
		.pt       (pt),
		.mat      (mat),
		.valid_s3 (f_valid),
		.n_s3     (f_n),
		.a_abs_s3 (f_a),
		.b_abs_s3 (f_b),
		.w_abs_s3 (f_w),
		.z_s3     (f_z),
		.flag_s3  (f_flag)
	);

	lpcp_iter #(
		.ACC_W (ACC_W)
	) u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.n         (f_n),
		.a_abs     (f_a),
		.b_abs     (f_b),
		.w_abs     (f_w),
		.z         (f_z),
		.flag      (f_flag),
		.out_valid (i_valid),
		.root      (i_root),
		.col_q     (i_col),
		.row_q     (i_row),
		.z_out     (i_z),
		.flag_out  (i_flag)
	);

	lpcp_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (i_valid),
		.root      (i_root),
		.col_q     (i_col),
		.row_q     (i_row),
		.z         (i_z),
		.flag      (i_flag),
		.band      (cfg_q[6]),
		.size      (cfg_q[7][31:0]),
		.res_valid (res_valid),
		.res       (res)
	);

`ifndef SYNTHESIS
	a_inside_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == lpcp_pkg::ST_INSIDE |->
			res.pixel_col < cfg_q[7][15:0] && res.pixel_row < cfg_q[7][31:16])
		else $error("inside result lies off the image");

	a_zero_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != lpcp_pkg::ST_INSIDE |->
			res.pixel_col == '0 && res.pixel_row == '0)
		else $error("rejected result carries a pixel");

	a_empty_image: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (cfg_q[7][15:0] == '0 || cfg_q[7][31:16] == '0) |->
			res.status != lpcp_pkg::ST_INSIDE)
		else $error("inside result with empty image");
`endif

endmodule
